// ===== design/tcjl_pkg.sv =====
package tcjl_pkg;

  localparam logic [1:0] ACT_CONVERT = 2'd0;
  localparam logic [1:0] ACT_COEF    = 2'd1;
  localparam logic [1:0] ACT_HEADER  = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FWD_SEGS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_SEGS = 2'd1;

  // binary64 constants
  localparam logic [63:0] K_AMPS_LSB  = 64'h3F44_7AE1_47AE_147B; // 0.000625
  localparam logic [63:0] K_SENSE     = 64'h3F99_9999_9999_999A; // 0.025
  localparam logic [63:0] K_DEG_LSB   = 64'h3FC0_0000_0000_0000; // 0.125
  localparam logic [63:0] K_MILLI     = 64'h3F50_624D_D2F1_A9FC; // 0.001
  localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FP_QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [62:0] FP_INF_MAG     = 63'h7FF0_0000_0000_0000;

  typedef enum logic [1:0] {OP_ADD, OP_MUL, OP_CVT} fp_op_t;

  typedef struct packed {
    logic        start;
    fp_op_t      op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

  typedef enum logic [2:0] {
    FP_IDLE, FP_ALIGN, FP_ADD, FP_MUL, FP_NORM, FP_DENORM, FP_ROUND, FP_DONE
  } fpu_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_AMPS_CVT, SQ_AMPS_MUL, SQ_VOLTS, SQ_CELS_CVT, SQ_CELS_MUL,
    SQ_SEARCH, SQ_TOP_RD, SQ_TOP_LD, SQ_HMUL, SQ_HRD, SQ_HADD, SQ_SCALE,
    SQ_OFFSET, SQ_PUT
  } seq_state_t;

  function automatic logic fp_is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [63:0] x);
    return x[62:0] == FP_INF_MAG;
  endfunction

  function automatic logic fp_is_zero(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

  function automatic logic [52:0] fp_mant(input logic [63:0] x);
    return {x[62:52] != 11'd0, x[51:0]};
  endfunction

  // subnormals share the exponent of the smallest normal
  function automatic logic [10:0] fp_bexp(input logic [63:0] x);
    return (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
  endfunction

  // ordered greater-than; false when either side is NaN
  function automatic logic fp_gt(input logic [63:0] a, input logic [63:0] b);
    logic r;
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_zero(a) && fp_is_zero(b))) begin
      r = 1'b0;
    end else if (a[63] != b[63]) begin
      r = b[63];
    end else if (!a[63]) begin
      r = a[62:0] > b[62:0];
    end else begin
      r = a[62:0] < b[62:0];
    end
    return r;
  endfunction

  // right shift, shifted-out bits ORed into the lsb
  function automatic logic [127:0] shr_sticky(input logic [127:0] v, input logic [11:0] sh);
    logic [127:0] mask;
    logic [127:0] r;
    if (sh >= 12'd128) begin
      r = {127'd0, |v};
    end else begin
      mask = (128'd1 << sh[6:0]) - 128'd1;
      r = (v >> sh[6:0]) | {127'd0, |(v & mask)};
    end
    return r;
  endfunction

endpackage

// ===== design/tcjl_if.sv =====
interface tcjl_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        table_select;
  logic [1:0]  segment;
  logic [3:0]  coef_index;
  logic [63:0] load_value;
  logic [15:0] raw_current;
  logic [15:0] raw_temperature;

  modport source (output valid, action, table_select, segment, coef_index, load_value,
                  raw_current, raw_temperature, input ready);
  modport sink (input valid, action, table_select, segment, coef_index, load_value,
                raw_current, raw_temperature, output ready);
endinterface

interface tcjl_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] thermo_temperature;
  logic [63:0] junction_celsius;
  logic [63:0] sense_volts;
  logic [63:0] current_amps;

  modport source (output valid, thermo_temperature, junction_celsius, sense_volts,
                  current_amps, input ready);
  modport sink (input valid, thermo_temperature, junction_celsius, sense_volts,
                current_amps, output ready);
endinterface

interface tcjl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tcjl_pkg::CFG_INDEX_W-1:0]    index;
  logic [tcjl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/thermocouple_cold_junction_linearizer.sv =====
// Channel  Role    Payload
// item     sink    action, table_select, segment, coef_index, load_value, raw words
// result   source  thermo_temperature, junction_celsius, sense_volts, current_amps
// cfg      sink    index, data (segment counts, always ready)
//
// A load is written when it is accepted. A convert runs on the single shared binary64
// unit (multiply as four partial products, stepped normalisation) with one coefficient
// memory read per polynomial term of both selected segments.
// Reset is synchronous; it clears the coefficient valid bits at once, no sweep.
// item stalls while a convert runs; the finished result sits in the output register
// and the next transaction is taken while it waits.
module thermocouple_cold_junction_linearizer #(
  parameter int MAX_SEGMENTS = 4,
  parameter int MAX_COEFS    = 16
) (
  input logic           clk,
  input logic           rst,
  tcjl_item_if.sink     item,
  tcjl_result_if.source result,
  tcjl_cfg_if.sink      cfg
);

  localparam int CDEPTH = 2 * MAX_SEGMENTS * MAX_COEFS;
  localparam int AW     = $clog2(CDEPTH);
  localparam int TDEPTH = 2 * MAX_SEGMENTS;
  localparam int TW     = $clog2(TDEPTH);
  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  tcjl_pkg::seq_state_t st, st_next;

  logic [tcjl_pkg::CFG_DATA_W-1:0] fwd_segs;
  logic [tcjl_pkg::CFG_DATA_W-1:0] inv_segs;
  logic [63:0]       thr [TDEPTH];
  logic [3:0]        ord [TDEPTH];
  logic [CDEPTH-1:0] cvalid;
  logic              rd_ok;
  logic              pend;
  logic [15:0]       raw_cur;
  logic [15:0]       raw_tmp;
  logic [63:0]       tmp;
  logic [63:0]       amps;
  logic [63:0]       volts;
  logic [63:0]       cels;
  logic [63:0]       xval;
  logic [63:0]       acc;
  logic              tbl;
  logic [SEG_W-1:0]  r;
  logic [3:0]        k;
  logic              out_valid;
  logic [63:0]       out_thermo;
  logic [63:0]       out_cels;
  logic [63:0]       out_volts;
  logic [63:0]       out_amps;

  logic              accept;
  logic              fp_state;
  logic              fp_done;
  logic [TW-1:0]     tidx;
  logic              hit;
  logic [3:0]        rd_k;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [63:0]       ram_rdata;
  logic [63:0]       coef;
  logic [3:0]        fwd_n;
  logic [3:0]        inv_n;
  logic              put_ok;
  tcjl_pkg::fpu_req_t freq;
  tcjl_pkg::fpu_rsp_t frsp;

  assign accept = item.valid && item.ready;
  assign fp_done = frsp.done && pend;
  assign put_ok = !out_valid || result.ready;

  // zero counts as one, large values saturate
  always_comb begin
    fwd_n = (fwd_segs == '0) ? 4'd1 :
            ({1'b0, fwd_segs} > 4'(MAX_SEGMENTS)) ? 4'(MAX_SEGMENTS) : {1'b0, fwd_segs};
    inv_n = (inv_segs == '0) ? 4'd1 :
            ({1'b0, inv_segs} > 4'(MAX_SEGMENTS)) ? 4'(MAX_SEGMENTS) : {1'b0, inv_segs};
  end

  assign tidx = TW'(int'(tbl) * MAX_SEGMENTS + int'(r));
  assign hit  = (r == '0) || tcjl_pkg::fp_gt(xval, thr[tidx]);
  assign rd_k = (st == tcjl_pkg::SQ_TOP_RD) ? ord[tidx] : k;
  assign coef = rd_ok ? ram_rdata : 64'd0;

  assign ram_we = accept && (item.action == tcjl_pkg::ACT_COEF) &&
                  (int'(item.segment) < MAX_SEGMENTS) && (int'(item.coef_index) < MAX_COEFS);
  assign ram_waddr = AW'((int'(item.table_select) * MAX_SEGMENTS + int'(item.segment))
                         * MAX_COEFS + int'(item.coef_index));
  assign ram_raddr = AW'(int'(tidx) * MAX_COEFS + int'(rd_k));

  tcjl_ram #(
    .WIDTH(64),
    .DEPTH(CDEPTH)
  ) u_coef_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(item.load_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tcjl_fpu u_fpu (
    .clk(clk),
    .rst(rst),
    .req(freq),
    .rsp(frsp)
  );

  // outputs
  always_comb begin
    item.ready = (st == tcjl_pkg::SQ_IDLE);
    cfg.ready  = 1'b1;
    ram_re     = (st == tcjl_pkg::SQ_TOP_RD) || (st == tcjl_pkg::SQ_HRD);
    fp_state   = 1'b1;
    freq.op    = tcjl_pkg::OP_MUL;
    freq.a     = acc;
    freq.b     = xval;
    case (st)
      tcjl_pkg::SQ_AMPS_CVT: begin
        freq.op = tcjl_pkg::OP_CVT;
        freq.a  = {48'd0, 16'($signed(raw_cur) >>> 3)};
      end
      tcjl_pkg::SQ_AMPS_MUL: begin freq.a = tmp;  freq.b = tcjl_pkg::K_AMPS_LSB; end
      tcjl_pkg::SQ_VOLTS:    begin freq.a = amps; freq.b = tcjl_pkg::K_SENSE;    end
      tcjl_pkg::SQ_CELS_CVT: begin
        freq.op = tcjl_pkg::OP_CVT;
        freq.a  = {48'd0, 16'($signed(raw_tmp) >>> 5)};
      end
      tcjl_pkg::SQ_CELS_MUL: begin freq.a = tmp; freq.b = tcjl_pkg::K_DEG_LSB; end
      tcjl_pkg::SQ_HMUL:     ;
      tcjl_pkg::SQ_HADD:     begin freq.op = tcjl_pkg::OP_ADD; freq.b = coef; end
      tcjl_pkg::SQ_SCALE:    freq.b = tcjl_pkg::K_MILLI;
      tcjl_pkg::SQ_OFFSET:   begin freq.op = tcjl_pkg::OP_ADD; freq.b = volts; end
      default:               fp_state = 1'b0;
    endcase
    freq.start = fp_state && !pend;
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      tcjl_pkg::SQ_IDLE:
        if (accept && (item.action == tcjl_pkg::ACT_CONVERT)) st_next = tcjl_pkg::SQ_AMPS_CVT;
      tcjl_pkg::SQ_AMPS_CVT: if (fp_done) st_next = tcjl_pkg::SQ_AMPS_MUL;
      tcjl_pkg::SQ_AMPS_MUL: if (fp_done) st_next = tcjl_pkg::SQ_VOLTS;
      tcjl_pkg::SQ_VOLTS:    if (fp_done) st_next = tcjl_pkg::SQ_CELS_CVT;
      tcjl_pkg::SQ_CELS_CVT: if (fp_done) st_next = tcjl_pkg::SQ_CELS_MUL;
      tcjl_pkg::SQ_CELS_MUL: if (fp_done) st_next = tcjl_pkg::SQ_SEARCH;
      tcjl_pkg::SQ_SEARCH:   if (hit) st_next = tcjl_pkg::SQ_TOP_RD;
      tcjl_pkg::SQ_TOP_RD:   st_next = tcjl_pkg::SQ_TOP_LD;
      tcjl_pkg::SQ_TOP_LD: begin
        if (k != 4'd0) st_next = tcjl_pkg::SQ_HMUL;
        else st_next = tbl ? tcjl_pkg::SQ_PUT : tcjl_pkg::SQ_SCALE;
      end
      tcjl_pkg::SQ_HMUL:     if (fp_done) st_next = tcjl_pkg::SQ_HRD;
      tcjl_pkg::SQ_HRD:      st_next = tcjl_pkg::SQ_HADD;
      tcjl_pkg::SQ_HADD: begin
        if (fp_done) begin
          if (k != 4'd0) st_next = tcjl_pkg::SQ_HMUL;
          else st_next = tbl ? tcjl_pkg::SQ_PUT : tcjl_pkg::SQ_SCALE;
        end
      end
      tcjl_pkg::SQ_SCALE:    if (fp_done) st_next = tcjl_pkg::SQ_OFFSET;
      tcjl_pkg::SQ_OFFSET:   if (fp_done) st_next = tcjl_pkg::SQ_SEARCH;
      tcjl_pkg::SQ_PUT:      if (put_ok) st_next = tcjl_pkg::SQ_IDLE;
      default:               st_next = tcjl_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= tcjl_pkg::SQ_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      fwd_segs  <= tcjl_pkg::CFG_DATA_W'(1);
      inv_segs  <= tcjl_pkg::CFG_DATA_W'(1);
      cvalid    <= '0;
      for (int i = 0; i < TDEPTH; i++) begin
        thr[i] <= 64'd0;
        ord[i] <= 4'd0;
      end
    end else begin
      st <= st_next;
      if (freq.start) begin
        pend <= 1'b1;
      end else if (fp_done) begin
        pend <= 1'b0;
      end
      if ((st == tcjl_pkg::SQ_PUT) && put_ok) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          tcjl_pkg::CFG_FWD_SEGS: fwd_segs <= cfg.data;
          tcjl_pkg::CFG_INV_SEGS: inv_segs <= cfg.data;
          default: ;
        endcase
      end
      if (ram_we) begin
        cvalid[ram_waddr] <= 1'b1;
      end
      if (accept && (item.action == tcjl_pkg::ACT_HEADER) &&
          (int'(item.segment) < MAX_SEGMENTS)) begin
        thr[TW'(int'(item.table_select) * MAX_SEGMENTS + int'(item.segment))] <=
          item.load_value;
        ord[TW'(int'(item.table_select) * MAX_SEGMENTS + int'(item.segment))] <=
          (int'(item.coef_index) < MAX_COEFS) ? item.coef_index : 4'(MAX_COEFS - 1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_ok <= cvalid[ram_raddr];
    end
    case (st)
      tcjl_pkg::SQ_IDLE: begin
        raw_cur <= item.raw_current;
        raw_tmp <= item.raw_temperature;
      end
      tcjl_pkg::SQ_AMPS_CVT: if (fp_done) tmp <= frsp.res;
      tcjl_pkg::SQ_AMPS_MUL: if (fp_done) amps <= frsp.res;
      tcjl_pkg::SQ_VOLTS:    if (fp_done) volts <= frsp.res;
      tcjl_pkg::SQ_CELS_CVT: if (fp_done) tmp <= frsp.res;
      tcjl_pkg::SQ_CELS_MUL: begin
        if (fp_done) begin
          cels <= frsp.res;
          xval <= frsp.res;
          tbl  <= 1'b0;
          r    <= SEG_W'(fwd_n - 4'd1);
        end
      end
      tcjl_pkg::SQ_SEARCH:   if (!hit) r <= r - SEG_W'(1);
      tcjl_pkg::SQ_TOP_RD:   k <= ord[tidx];
      tcjl_pkg::SQ_TOP_LD:   acc <= coef;
      tcjl_pkg::SQ_HMUL: begin
        if (fp_done) begin
          acc <= frsp.res;
          k   <= k - 4'd1;
        end
      end
      tcjl_pkg::SQ_HADD:     if (fp_done) acc <= frsp.res;
      tcjl_pkg::SQ_SCALE:    if (fp_done) acc <= frsp.res;
      tcjl_pkg::SQ_OFFSET: begin
        if (fp_done) begin
          xval <= frsp.res;
          tbl  <= 1'b1;
          r    <= SEG_W'(inv_n - 4'd1);
        end
      end
      tcjl_pkg::SQ_PUT: begin
        if (put_ok) begin
          out_thermo <= acc;
          out_cels   <= cels;
          out_volts  <= volts;
          out_amps   <= amps;
        end
      end
      default: ;
    endcase
  end

  assign result.valid              = out_valid;
  assign result.thermo_temperature = out_thermo;
  assign result.junction_celsius   = out_cels;
  assign result.sense_volts        = out_volts;
  assign result.current_amps       = out_amps;

  assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (st != tcjl_pkg::SQ_IDLE) && (st != tcjl_pkg::SQ_PUT))
    else $error("coefficient read outside an evaluation");
  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(st == tcjl_pkg::SQ_PUT))
    else $error("result raised without a finished convert");
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.thermo_temperature))
    else $error("waiting result changed or dropped");

endmodule

// ===== design/tcjl_ram.sv =====
module tcjl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tcjl_fpu.sv =====
module tcjl_fpu (
  input  logic               clk,
  input  logic               rst,
  input  tcjl_pkg::fpu_req_t req,
  output tcjl_pkg::fpu_rsp_t rsp
);

  tcjl_pkg::fpu_state_t st, st_next;

  logic               sgn;
  logic               sgn_y;
  logic signed [13:0] ex;
  logic [127:0]       m;
  logic [127:0]       my;
  logic [10:0]        dsh;
  logic [52:0]        ma;
  logic [52:0]        mb;
  logic [2:0]         cnt;
  logic [53:0]        pp;
  logic [5:0]         pp_sh;
  logic [10:0]        expf;
  logic [63:0]        res;

  logic               spec;
  logic [63:0]        spec_val;
  logic               a_big;
  logic [63:0]        opx;
  logic [63:0]        opy;
  logic [15:0]        cvt_abs;
  logic [26:0]        mul_x;
  logic [26:0]        mul_y;
  logic [5:0]         mul_sh;
  logic signed [13:0] bexp;
  logic [11:0]        sub_sh;
  logic               rnd_inc;

  // special operands
  always_comb begin
    spec     = 1'b0;
    spec_val = req.a | tcjl_pkg::FP_QUIET_BIT;
    case (req.op)
      tcjl_pkg::OP_MUL: begin
        if (tcjl_pkg::fp_is_nan(req.a)) begin
          spec = 1'b1;
        end else if (tcjl_pkg::fp_is_nan(req.b)) begin
          spec     = 1'b1;
          spec_val = req.b | tcjl_pkg::FP_QUIET_BIT;
        end else if ((tcjl_pkg::fp_is_inf(req.a) && tcjl_pkg::fp_is_zero(req.b)) ||
                     (tcjl_pkg::fp_is_zero(req.a) && tcjl_pkg::fp_is_inf(req.b))) begin
          spec     = 1'b1;
          spec_val = tcjl_pkg::FP_DEFAULT_NAN;
        end else if (tcjl_pkg::fp_is_inf(req.a) || tcjl_pkg::fp_is_inf(req.b)) begin
          spec     = 1'b1;
          spec_val = {req.a[63] ^ req.b[63], tcjl_pkg::FP_INF_MAG};
        end
      end
      tcjl_pkg::OP_ADD: begin
        if (tcjl_pkg::fp_is_nan(req.a)) begin
          spec = 1'b1;
        end else if (tcjl_pkg::fp_is_nan(req.b)) begin
          spec     = 1'b1;
          spec_val = req.b | tcjl_pkg::FP_QUIET_BIT;
        end else if (tcjl_pkg::fp_is_inf(req.a) && tcjl_pkg::fp_is_inf(req.b) &&
                     (req.a[63] != req.b[63])) begin
          spec     = 1'b1;
          spec_val = tcjl_pkg::FP_DEFAULT_NAN;
        end else if (tcjl_pkg::fp_is_inf(req.a)) begin
          spec     = 1'b1;
          spec_val = req.a;
        end else if (tcjl_pkg::fp_is_inf(req.b)) begin
          spec     = 1'b1;
          spec_val = req.b;
        end
      end
      default: ;
    endcase
  end

  assign a_big   = tcjl_pkg::fp_bexp(req.a) >= tcjl_pkg::fp_bexp(req.b);
  assign opx     = a_big ? req.a : req.b;
  assign opy     = a_big ? req.b : req.a;
  assign cvt_abs = req.a[15] ? (16'd0 - req.a[15:0]) : req.a[15:0];

  // 53x53 as four 27x27 partial products
  always_comb begin
    case (cnt[1:0])
      2'd0: begin mul_x = ma[26:0];         mul_y = mb[26:0];         mul_sh = 6'd0;  end
      2'd1: begin mul_x = ma[26:0];         mul_y = {1'b0, mb[52:27]}; mul_sh = 6'd27; end
      2'd2: begin mul_x = {1'b0, ma[52:27]}; mul_y = mb[26:0];         mul_sh = 6'd27; end
      default: begin
        mul_x = {1'b0, ma[52:27]}; mul_y = {1'b0, mb[52:27]}; mul_sh = 6'd54;
      end
    endcase
  end

  assign bexp    = ex + 14'sd1023;
  assign sub_sh  = 12'(14'sd1 - bexp);
  assign rnd_inc = m[74] & ((|m[73:0]) | m[75]);

  always_comb begin
    st_next = st;
    case (st)
      tcjl_pkg::FP_IDLE: begin
        if (req.start) begin
          if (spec) begin
            st_next = tcjl_pkg::FP_DONE;
          end else begin
            case (req.op)
              tcjl_pkg::OP_ADD: st_next = tcjl_pkg::FP_ALIGN;
              tcjl_pkg::OP_MUL: st_next = tcjl_pkg::FP_MUL;
              tcjl_pkg::OP_CVT: st_next = tcjl_pkg::FP_NORM;
              default:          st_next = tcjl_pkg::FP_DONE;
            endcase
          end
        end
      end
      tcjl_pkg::FP_ALIGN: st_next = tcjl_pkg::FP_ADD;
      tcjl_pkg::FP_ADD:   st_next = tcjl_pkg::FP_NORM;
      tcjl_pkg::FP_MUL:   if (cnt == 3'd4) st_next = tcjl_pkg::FP_NORM;
      tcjl_pkg::FP_NORM: begin
        if (m == 128'd0) begin
          st_next = tcjl_pkg::FP_DONE;
        end else if (m[127]) begin
          st_next = tcjl_pkg::FP_DENORM;
        end
      end
      tcjl_pkg::FP_DENORM: begin
        st_next = (bexp >= 14'sd2047) ? tcjl_pkg::FP_DONE : tcjl_pkg::FP_ROUND;
      end
      tcjl_pkg::FP_ROUND: st_next = tcjl_pkg::FP_DONE;
      tcjl_pkg::FP_DONE:  st_next = tcjl_pkg::FP_IDLE;
      default:            st_next = tcjl_pkg::FP_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (st == tcjl_pkg::FP_DONE);
    rsp.res  = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= tcjl_pkg::FP_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      tcjl_pkg::FP_IDLE: begin
        if (req.start) begin
          res <= spec_val;
          case (req.op)
            tcjl_pkg::OP_CVT: begin
              sgn <= req.a[15];
              m   <= {112'd0, cvt_abs};
              ex  <= 14'sd127;
            end
            tcjl_pkg::OP_MUL: begin
              ma  <= tcjl_pkg::fp_mant(req.a);
              mb  <= tcjl_pkg::fp_mant(req.b);
              ex  <= $signed({3'b000, tcjl_pkg::fp_bexp(req.a)}) +
                     $signed({3'b000, tcjl_pkg::fp_bexp(req.b)}) - 14'sd2023;
              sgn <= req.a[63] ^ req.b[63];
              m   <= 128'd0;
              cnt <= 3'd0;
            end
            default: begin
              m     <= {2'b00, tcjl_pkg::fp_mant(opx), 73'd0};
              my    <= {2'b00, tcjl_pkg::fp_mant(opy), 73'd0};
              dsh   <= tcjl_pkg::fp_bexp(opx) - tcjl_pkg::fp_bexp(opy);
              sgn   <= opx[63];
              sgn_y <= opy[63];
              ex    <= $signed({3'b000, tcjl_pkg::fp_bexp(opx)}) - 14'sd1021;
            end
          endcase
        end
      end
      tcjl_pkg::FP_ALIGN: my <= tcjl_pkg::shr_sticky(my, {1'b0, dsh});
      tcjl_pkg::FP_ADD: begin
        if (sgn == sgn_y) begin
          m <= m + my;
        end else if (m >= my) begin
          m <= m - my;
          if (m == my) sgn <= 1'b0; // exact cancellation gives +0
        end else begin
          m   <= my - m;
          sgn <= sgn_y;
        end
      end
      tcjl_pkg::FP_MUL: begin
        if (cnt != 3'd4) begin
          pp    <= mul_x * mul_y;
          pp_sh <= mul_sh;
        end
        if (cnt != 3'd0) begin
          m <= m + (128'(pp) << pp_sh);
        end
        cnt <= cnt + 3'd1;
      end
      tcjl_pkg::FP_NORM: begin
        if (m == 128'd0) begin
          res <= {sgn, 63'd0};
        end else if (m[127:96] == 32'd0) begin
          m  <= m << 32;
          ex <= ex - 14'sd32;
        end else if (m[127:120] == 8'd0) begin
          m  <= m << 8;
          ex <= ex - 14'sd8;
        end else if (m[127:124] == 4'd0) begin
          m  <= m << 4;
          ex <= ex - 14'sd4;
        end else if (!m[127]) begin
          m  <= m << 1;
          ex <= ex - 14'sd1;
        end
      end
      tcjl_pkg::FP_DENORM: begin
        if (bexp >= 14'sd2047) begin
          res <= {sgn, tcjl_pkg::FP_INF_MAG};
        end else if (bexp <= 14'sd0) begin
          m    <= tcjl_pkg::shr_sticky(m, sub_sh);
          expf <= 11'd0;
        end else begin
          expf <= bexp[10:0];
        end
      end
      tcjl_pkg::FP_ROUND: begin
        // carry out of the fraction moves into the exponent field
        res <= {sgn, {expf, m[126:75]} + {62'd0, rnd_inc}};
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) req.start |-> st == tcjl_pkg::FP_IDLE)
    else $error("fpu started while busy");
  assert property (@(posedge clk) disable iff (rst) rsp.done |=> !rsp.done)
    else $error("fpu done held longer than one cycle");
  assert property (@(posedge clk) disable iff (rst)
    st == tcjl_pkg::FP_DONE |=> st == tcjl_pkg::FP_IDLE)
    else $error("fpu did not return to idle after done");

endmodule

// ===== test/tb_thermocouple_cold_junction_linearizer.sv =====
module tb_thermocouple_cold_junction_linearizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = 4;
  localparam int NCOEF = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 150;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [tcjl_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [tcjl_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [63:0] thermo;
    logic [63:0] cels;
    logic [63:0] volts;
    logic [63:0] amps;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcjl_item_if   item_ch();
  tcjl_result_if res_ch();
  tcjl_cfg_if    cfg_ch();

  thermocouple_cold_junction_linearizer dut (
    .clk(clk), .rst(rst), .item(item_ch), .result(res_ch), .cfg(cfg_ch)
  );

  // shadow copy of the block state
  logic [63:0] coef_mem [2*NSEG*NCOEF];
  logic [63:0] thresh_mem [2*NSEG];
  logic [3:0]  order_mem [2*NSEG];
  logic [2:0]  fwd_reg, inv_reg;

  reading_t readings_due[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int converts_sent = 0;
  int loads_sent = 0;
  int cfg_writes = 0;
  int idle_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.action = tcjl_pkg::ACT_CONVERT;
    item_ch.table_select = 1'b0;
    item_ch.segment = '0;
    item_ch.coef_index = '0;
    item_ch.load_value = '0;
    item_ch.raw_current = '0;
    item_ch.raw_temperature = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tcjl_pkg::CFG_FWD_SEGS;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int seg_count(logic [2:0] r);
    int n;
    n = r;
    if (n == 0) n = 1;
    if (n > NSEG) n = NSEG;
    return n;
  endfunction

  function automatic real horner_segment(int tbl, int cnt, real x);
    int r;
    int k;
    int base;
    real acc;
    r = cnt - 1;
    while (r > 0) begin
      if (x > $bitstoreal(thresh_mem[tbl*NSEG + r])) break;
      r--;
    end
    k = order_mem[tbl*NSEG + r];
    base = (tbl*NSEG + r) * NCOEF;
    acc = $bitstoreal(coef_mem[base + k]);
    while (k > 0) begin
      k--;
      acc = $bitstoreal(coef_mem[base + k]) + acc * x;
    end
    return acc;
  endfunction

  function automatic void predict_reading(logic [1:0] act, logic tbl, logic [1:0] seg,
                                          logic [3:0] idx, logic [63:0] val,
                                          logic [15:0] rc, logic [15:0] rt);
    reading_t rd;
    int ci, ti;
    real amps, volts, cels, e, th;
    if (act == tcjl_pkg::ACT_COEF) begin
      coef_mem[(int'(tbl)*NSEG + int'(seg))*NCOEF + int'(idx)] = val;
    end else if (act == tcjl_pkg::ACT_HEADER) begin
      thresh_mem[int'(tbl)*NSEG + int'(seg)] = val;
      order_mem[int'(tbl)*NSEG + int'(seg)] = idx;
    end else if (act == tcjl_pkg::ACT_CONVERT) begin
      ci = $signed(rc) >>> 3;
      ti = $signed(rt) >>> 5;
      amps = real'(ci) * $bitstoreal(tcjl_pkg::K_AMPS_LSB);
      volts = amps * $bitstoreal(tcjl_pkg::K_SENSE);
      cels = real'(ti) * $bitstoreal(tcjl_pkg::K_DEG_LSB);
      e = horner_segment(0, seg_count(fwd_reg), cels);
      e = e * $bitstoreal(tcjl_pkg::K_MILLI);
      e = e + volts;
      th = horner_segment(1, seg_count(inv_reg), e);
      rd.thermo = $realtobits(th);
      rd.cels = $realtobits(cels);
      rd.volts = $realtobits(volts);
      rd.amps = $realtobits(amps);
      readings_due.push_back(rd);
    end
  endfunction

  function automatic logic is_nan64(logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 0);
  endfunction

  always @(posedge clk) begin
    reading_t want;
    logic bad;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        want = readings_due.pop_front();
        // NaN payloads are not architectural; any NaN matches a NaN
        bad = (is_nan64(want.thermo) ? !is_nan64(res_ch.thermo_temperature)
                                     : res_ch.thermo_temperature !== want.thermo)
              || res_ch.junction_celsius !== want.cels
              || res_ch.sense_volts !== want.volts
              || res_ch.current_amps !== want.amps;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  thermo exp %h got %h", want.thermo, res_ch.thermo_temperature);
            $display("  cels   exp %h got %h", want.cels, res_ch.junction_celsius);
            $display("  volts  exp %h got %h", want.volts, res_ch.sense_volts);
            $display("  amps   exp %h got %h", want.amps, res_ch.current_amps);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", readings_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] act, logic tbl, logic [1:0] seg, logic [3:0] idx,
                           logic [63:0] val, logic [15:0] rc, logic [15:0] rt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.action = act;
    item_ch.table_select = tbl;
    item_ch.segment = seg;
    item_ch.coef_index = idx;
    item_ch.load_value = val;
    item_ch.raw_current = rc;
    item_ch.raw_temperature = rt;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_reading(act, tbl, seg, idx, val, rc, rt);
    if (act == tcjl_pkg::ACT_CONVERT) converts_sent++;
    else loads_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [tcjl_pkg::CFG_INDEX_W-1:0] idx,
                           logic [tcjl_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == tcjl_pkg::CFG_FWD_SEGS) fwd_reg = val;
    else if (idx == tcjl_pkg::CFG_INV_SEGS) inv_reg = val;
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [63:0] rand_coef();
    logic [63:0] v;
    if ($urandom_range(19) == 0) return 64'd0;
    // bounded exponent keeps the polynomials mostly finite
    v = {$urandom, $urandom};
    v[62:52] = 11'h3F0 + 11'($urandom_range(31));
    return v;
  endfunction

  function automatic logic [63:0] rand_thresh(logic tbl);
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    if (tbl) return $realtobits((real'($urandom_range(2000)) - 1000.0) * 0.0001);
    return $realtobits(real'($urandom_range(2400)) * 0.125 - 150.0);
  endfunction

  function automatic logic [3:0] rand_order();
    if ($urandom_range(39) == 0) return 4'd15;
    return 4'($urandom_range(4));
  endfunction

  task automatic test_directed;
    send_item(tcjl_pkg::ACT_CONVERT, 0, 0, 0, 0, 16'h0000, 16'h0000);
    send_item(tcjl_pkg::ACT_COEF, 0, 0, 0, 64'h3FF0_0000_0000_0000, 0, 0);
    send_item(tcjl_pkg::ACT_COEF, 0, 0, 1, 64'h4039_0000_0000_0000, 0, 0);
    send_item(tcjl_pkg::ACT_HEADER, 0, 0, 1, 64'd0, 0, 0);
    send_item(tcjl_pkg::ACT_COEF, 1, 0, 0, 64'hBFF8_0000_0000_0000, 0, 0);
    send_item(tcjl_pkg::ACT_COEF, 1, 0, 1, 64'h4059_0000_0000_0000, 0, 0);
    send_item(tcjl_pkg::ACT_HEADER, 1, 0, 1, 64'd0, 0, 0);
    send_item(tcjl_pkg::ACT_CONVERT, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF);
    send_item(tcjl_pkg::ACT_CONVERT, 0, 0, 0, 0, 16'h8000, 16'h8000);
    send_item(tcjl_pkg::ACT_CONVERT, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
    // unused action code: ignored
    send_item(ACT_UNUSED, 1, 3, 15, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234, 16'h5678);
    // top segments, NaN threshold fails the test, highest order
    send_item(tcjl_pkg::ACT_HEADER, 0, 3, 15, 64'h7FF8_0000_0000_0001, 0, 0);
    send_item(tcjl_pkg::ACT_HEADER, 0, 2, 2, 64'hC059_0000_0000_0000, 0, 0);
    send_item(tcjl_pkg::ACT_COEF, 0, 2, 15, 64'hBF80_0000_0000_0001, 0, 0);
    send_item(tcjl_pkg::ACT_COEF, 0, 3, 15, 64'h3FE0_0000_0000_0000, 0, 0);
    send_item(tcjl_pkg::ACT_HEADER, 1, 3, 15, 64'hFFF0_0000_0000_0000, 0, 0);
    send_item(tcjl_pkg::ACT_CONVERT, 0, 0, 0, 0, 16'h0040, 16'h1900);
    drain();
    // count register zero reads as one, above the maximum saturates
    write_reg(tcjl_pkg::CFG_FWD_SEGS, 3'd7);
    write_reg(tcjl_pkg::CFG_INV_SEGS, 3'd0);
    write_reg(CFG_SPARE_A, 3'd5);
    write_reg(CFG_SPARE_B, 3'd2);
    send_item(tcjl_pkg::ACT_CONVERT, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF);
    send_item(tcjl_pkg::ACT_CONVERT, 0, 0, 0, 0, 16'hF000, 16'hE000);
    drain();
    write_reg(tcjl_pkg::CFG_INV_SEGS, 3'd5);
    send_item(tcjl_pkg::ACT_CONVERT, 0, 0, 0, 0, 16'h0100, 16'h0320);
    drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct, logic [2:0] fsegs,
                             logic [2:0] isegs, logic hold);
    int p;
    logic tbl;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(tcjl_pkg::CFG_FWD_SEGS, fsegs);
    write_reg(tcjl_pkg::CFG_INV_SEGS, isegs);
    for (int n = 0; n < count; n++) begin
      if (hold && n == count / 2) drain();
      p = $urandom_range(99);
      tbl = $urandom_range(1);
      if (p < 45) begin
        send_item(tcjl_pkg::ACT_CONVERT, tbl, 2'($urandom), 4'($urandom),
                  {$urandom, $urandom}, 16'($urandom), 16'($urandom));
      end else if (p < 80) begin
        send_item(tcjl_pkg::ACT_COEF, tbl, 2'($urandom), 4'($urandom), rand_coef(),
                  16'($urandom), 16'($urandom));
      end else if (p < 95) begin
        send_item(tcjl_pkg::ACT_HEADER, tbl, 2'($urandom), rand_order(), rand_thresh(tbl),
                  16'($urandom), 16'($urandom));
      end else begin
        send_item(ACT_UNUSED, tbl, 2'($urandom), 4'($urandom), {$urandom, $urandom},
                  16'($urandom), 16'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 2*NSEG*NCOEF; i++) coef_mem[i] = '0;
    for (int i = 0; i < 2*NSEG; i++) begin
      thresh_mem[i] = '0;
      order_mem[i] = '0;
    end
    fwd_reg = 3'd1;
    inv_reg = 3'd1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(430, 0, 0, 3'd4, 3'd4, 1'b0);
    test_random(430, 60, 0, 3'd1, 3'd2, 1'b1);
    test_random(430, 0, 60, 3'd2, 3'd3, 1'b0);
    test_random(430, 14, 14, 3'd3, 3'd1, 1'b0);
    $display("covered %0d conversions, %0d loads, %0d register writes", converts_sent,
             loads_sent, cfg_writes);
    $display("under four idle and stall mixes, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
